[rtl/tnf_pkg.sv]
// tnf_pkg: shared widths, types and stage counts for the tangent frame pipeline
// no dependencies; imported by every module under rtl
package tnf_pkg;

	// component format and packed vector width
	localparam int CB = 16;
	localparam int NF = CB - 2;
	localparam int VW = 3 * CB;
	localparam int UVW = 2 * CB;

	// wide signed vector components fed to the normaliser
	localparam int IW = 2 * CB + 4;
	localparam int IXW = $clog2(IW);

	// normaliser internals: magnitudes lifted into [2^29, 2^30)
	localparam int MAGW = 30;
	localparam int LIFT = MAGW - 1;
	localparam int L2W = 2 * MAGW + 2;
	localparam int RTW = MAGW + 1;
	localparam int QW = NF + 1;
	localparam int NUMW = MAGW + NF + 2;
	localparam int NORM_LAT = 5 + RTW + 1 + QW + 1;

	// projection widths
	localparam int PRW = CB + 5;
	localparam int PW = 2 * CB + 3;

	// sideband carried alongside each normaliser
	localparam int SIDE_W = 3 * CB + 3;

	typedef logic signed [CB-1:0] comp_t;
	typedef logic signed [CB:0] edge_t;
	typedef logic signed [IW-1:0] wide_t;
	typedef logic [SIDE_W-1:0] side_t;

endpackage

[rtl/tnf_norm.sv]
// tnf_norm: pipelined unit-vector normaliser with a sideband carried in step
// depends on tnf_pkg; bit-serial square root and per-component dividers
module tnf_norm
	import tnf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  wide_t vin [3],
	input  side_t side_in,
	output logic  out_valid,
	output comp_t vout [3],
	output logic  nz,
	output side_t side_out
);

	// valid and sideband delay line
	logic [NORM_LAT-1:0] vld_s;
	side_t side_s [NORM_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[NORM_LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		side_s[0] <= side_in;
		for (int k = 1; k < NORM_LAT; k++) begin
			side_s[k] <= side_s[k-1];
		end
	end

	assign out_valid = vld_s[NORM_LAT-1];
	assign side_out = side_s[NORM_LAT-1];

	// stage 1: magnitudes, signs and largest magnitude
	logic [IW-1:0] mag_c [3];
	logic [IW-1:0] mx_c;
	logic [IW-1:0] mag_s1 [3];
	logic [2:0] neg_s1;
	logic [IW-1:0] mx_s1;

	always_comb begin
		mx_c = '0;
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = vin[i][IW-1] ? IW'(-vin[i]) : IW'(vin[i]);
			if (mag_c[i] > mx_c) begin
				mx_c = mag_c[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		mag_s1 <= mag_c;
		mx_s1 <= mx_c;
		for (int i = 0; i < 3; i++) begin
			neg_s1[i] <= vin[i][IW-1];
		end
	end

	// stage 2: leading one of the largest magnitude
	logic [IXW-1:0] pos_c;
	logic [IXW-1:0] pos_s2;
	logic [IW-1:0] mag_s2 [3];
	logic [2:0] neg_s2;
	logic nz_s2;

	always_comb begin
		pos_c = '0;
		for (int b = 0; b < IW; b++) begin
			if (mx_s1[b]) begin
				pos_c = IXW'(b);
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_s2 <= pos_c;
		mag_s2 <= mag_s1;
		neg_s2 <= neg_s1;
		nz_s2 <= |mx_s1;
	end

	// stage 3: scale so the largest lies in [2^29, 2^30), low bits truncated
	logic [IW+LIFT-1:0] ext_c [3];
	logic [MAGW-1:0] mag_s3 [3];
	logic [2:0] neg_s3;
	logic nz_s3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ext_c[i] = {mag_s2[i], {LIFT{1'b0}}} >> pos_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			mag_s3[i] <= ext_c[i][MAGW-1:0];
		end
		neg_s3 <= neg_s2;
		nz_s3 <= nz_s2;
	end

	// stage 4: squares
	logic [2*MAGW-1:0] sq_s4 [3];
	logic [MAGW-1:0] mag_s4 [3];
	logic [2:0] neg_s4;
	logic nz_s4;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s4[i] <= mag_s3[i] * mag_s3[i];
		end
		mag_s4 <= mag_s3;
		neg_s4 <= neg_s3;
		nz_s4 <= nz_s3;
	end

	// stage 5: squared length
	logic [L2W-1:0] l2_s5;
	logic [MAGW-1:0] mag_s5 [3];
	logic [2:0] neg_s5;
	logic nz_s5;

	always_ff @(posedge clk) begin
		l2_s5 <= L2W'(sq_s4[0]) + L2W'(sq_s4[1]) + L2W'(sq_s4[2]);
		mag_s5 <= mag_s4;
		neg_s5 <= neg_s4;
		nz_s5 <= nz_s4;
	end

	// square root, one result bit per stage from the top
	logic [L2W-1:0] rt_rem_s6 [RTW];
	logic [RTW-1:0] rt_root_s6 [RTW];
	logic [MAGW-1:0] rt_mag_s6 [RTW][3];
	logic [2:0] rt_neg_s6 [RTW];
	logic rt_nz_s6 [RTW];

	for (genvar j = 0; j < RTW; j++) begin : g_sqrt
		localparam int K = RTW - 1 - j;
		logic [L2W-1:0] rem_in;
		logic [RTW-1:0] root_in;
		logic [MAGW-1:0] mag_in [3];
		logic [2:0] neg_in;
		logic nz_in;
		logic [L2W:0] trial;

		if (j == 0) begin : g_first
			assign rem_in = l2_s5;
			assign root_in = '0;
			assign mag_in = mag_s5;
			assign neg_in = neg_s5;
			assign nz_in = nz_s5;
		end else begin : g_next
			assign rem_in = rt_rem_s6[j-1];
			assign root_in = rt_root_s6[j-1];
			assign mag_in = rt_mag_s6[j-1];
			assign neg_in = rt_neg_s6[j-1];
			assign nz_in = rt_nz_s6[j-1];
		end

		// (r + 2^k)^2 - r^2
		assign trial = ((L2W+1)'(root_in) << (K + 1)) + ((L2W+1)'(1) << (2 * K));

		always_ff @(posedge clk) begin
			if ({1'b0, rem_in} >= trial) begin
				rt_rem_s6[j] <= L2W'({1'b0, rem_in} - trial);
				rt_root_s6[j] <= root_in | (RTW'(1) << K);
			end else begin
				rt_rem_s6[j] <= rem_in;
				rt_root_s6[j] <= root_in;
			end
			rt_mag_s6[j] <= mag_in;
			rt_neg_s6[j] <= neg_in;
			rt_nz_s6[j] <= nz_in;
		end
	end

	// stage 7: rounded numerators
	logic [NUMW-1:0] num_s7 [3];
	logic [RTW-1:0] m_s7;
	logic [2:0] neg_s7;
	logic nz_s7;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			num_s7[i] <= (NUMW'(rt_mag_s6[RTW-1][i]) << NF)
				+ NUMW'(rt_root_s6[RTW-1] >> 1);
		end
		m_s7 <= rt_root_s6[RTW-1];
		neg_s7 <= rt_neg_s6[RTW-1];
		nz_s7 <= rt_nz_s6[RTW-1];
	end

	// restoring dividers, one quotient bit per stage
	logic [NUMW-1:0] dv_rem_s8 [QW][3];
	logic [QW-1:0] dv_q_s8 [QW][3];
	logic [RTW-1:0] dv_m_s8 [QW];
	logic [2:0] dv_neg_s8 [QW];
	logic dv_nz_s8 [QW];

	for (genvar j = 0; j < QW; j++) begin : g_div
		localparam int K = QW - 1 - j;
		logic [NUMW-1:0] rem_in [3];
		logic [QW-1:0] q_in [3];
		logic [RTW-1:0] m_in;
		logic [2:0] neg_in;
		logic nz_in;
		logic [NUMW-1:0] dvsr;

		if (j == 0) begin : g_first
			assign rem_in = num_s7;
			assign q_in = '{default: '0};
			assign m_in = m_s7;
			assign neg_in = neg_s7;
			assign nz_in = nz_s7;
		end else begin : g_next
			assign rem_in = dv_rem_s8[j-1];
			assign q_in = dv_q_s8[j-1];
			assign m_in = dv_m_s8[j-1];
			assign neg_in = dv_neg_s8[j-1];
			assign nz_in = dv_nz_s8[j-1];
		end

		assign dvsr = NUMW'(m_in) << K;

		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				if (rem_in[i] >= dvsr) begin
					dv_rem_s8[j][i] <= rem_in[i] - dvsr;
					dv_q_s8[j][i] <= q_in[i] | (QW'(1) << K);
				end else begin
					dv_rem_s8[j][i] <= rem_in[i];
					dv_q_s8[j][i] <= q_in[i];
				end
			end
			dv_m_s8[j] <= m_in;
			dv_neg_s8[j] <= neg_in;
			dv_nz_s8[j] <= nz_in;
		end
	end

	// stage 9: sign restored; quotient never exceeds the positive limit
	comp_t vout_s9 [3];
	logic nz_s9;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			vout_s9[i] <= dv_neg_s8[QW-1][i] ? -comp_t'(dv_q_s8[QW-1][i])
				: comp_t'(dv_q_s8[QW-1][i]);
		end
		nz_s9 <= dv_nz_s8[QW-1];
	end

	assign vout = vout_s9;
	assign nz = nz_s9;

endmodule

[rtl/tnf_front.sv]
// tnf_front: corner normal sum and oriented edge, one register stage
// depends on tnf_pkg
module tnf_front
	import tnf_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [VW-1:0] pos_a,
	input  logic [VW-1:0] pos_b,
	input  logic [VW-1:0] pos_c,
	input  logic [VW-1:0] nrm_a,
	input  logic [VW-1:0] nrm_b,
	input  logic [VW-1:0] nrm_c,
	input  logic [UVW-1:0] uv_a,
	input  logic [UVW-1:0] uv_b,
	output logic          out_valid,
	output wide_t         nsum [3],
	output side_t         edge_out
);

	logic [VW-1:0] far_c;
	edge_t du_c;
	edge_t d_c [3];
	wide_t s_c [3];

	// edge to corner 1, or to corner 2 when corners 0 and 1 coincide
	always_comb begin
		far_c = (pos_a == pos_b) ? pos_c : pos_b;
		du_c = edge_t'(comp_t'(uv_b[CB-1:0])) - edge_t'(comp_t'(uv_a[CB-1:0]));
		for (int i = 0; i < 3; i++) begin
			d_c[i] = edge_t'(comp_t'(far_c[i*CB +: CB])) - edge_t'(comp_t'(pos_a[i*CB +: CB]));
			if (du_c[CB]) begin
				d_c[i] = -d_c[i];
			end
			s_c[i] = wide_t'(comp_t'(nrm_a[i*CB +: CB])) + wide_t'(comp_t'(nrm_b[i*CB +: CB]))
				+ wide_t'(comp_t'(nrm_c[i*CB +: CB]));
		end
	end

	logic vld_s1;
	wide_t s_s1 [3];
	side_t d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		s_s1 <= s_c;
		d_s1 <= {d_c[2], d_c[1], d_c[0]};
	end

	assign out_valid = vld_s1;
	assign nsum = s_s1;
	assign edge_out = d_s1;

endmodule

[rtl/tnf_proj.sv]
// tnf_proj: removes the normal component from the edge, five register stages
// depends on tnf_pkg
module tnf_proj
	import tnf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  comp_t nrm [3],
	input  logic  nrm_ok,
	input  side_t edge_in,
	output logic  out_valid,
	output wide_t wvec [3],
	output side_t side_out
);

	logic [4:0] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[3:0], in_valid};
		end
	end

	// stage 1: products n_i d_i
	logic signed [2*CB:0] pd_s1 [3];
	comp_t n_s1 [3];
	edge_t d_s1 [3];
	logic ok_s1;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pd_s1[i] <= nrm[i] * edge_t'(edge_in[i*(CB+1) +: CB+1]);
			d_s1[i] <= edge_t'(edge_in[i*(CB+1) +: CB+1]);
		end
		n_s1 <= nrm;
		ok_s1 <= nrm_ok;
	end

	// stage 2: dot product
	logic signed [PW-1:0] p_s2;
	comp_t n_s2 [3];
	edge_t d_s2 [3];
	logic ok_s2;

	always_ff @(posedge clk) begin
		p_s2 <= PW'(pd_s1[0]) + PW'(pd_s1[1]) + PW'(pd_s1[2]);
		n_s2 <= n_s1;
		d_s2 <= d_s1;
		ok_s2 <= ok_s1;
	end

	// stage 3: round to edge units, half away from zero
	logic [PW-1:0] pm_c;
	logic [PW-1:0] pr_c;
	logic signed [PRW-1:0] pr_s3;
	comp_t n_s3 [3];
	edge_t d_s3 [3];
	logic ok_s3;

	always_comb begin
		pm_c = p_s2[PW-1] ? PW'(-p_s2) : PW'(p_s2);
		pr_c = (pm_c + (PW'(1) << (NF - 1))) >> NF;
	end

	always_ff @(posedge clk) begin
		pr_s3 <= p_s2[PW-1] ? -$signed(PRW'(pr_c)) : $signed(PRW'(pr_c));
		n_s3 <= n_s2;
		d_s3 <= d_s2;
		ok_s3 <= ok_s2;
	end

	// stage 4: p n_i and scaled edge
	logic signed [PRW+CB-1:0] pn_s4 [3];
	wide_t dsh_s4 [3];
	comp_t n_s4 [3];
	logic ok_s4;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pn_s4[i] <= pr_s3 * n_s3[i];
			dsh_s4[i] <= wide_t'(d_s3[i]) <<< NF;
		end
		n_s4 <= n_s3;
		ok_s4 <= ok_s3;
	end

	// stage 5: orthogonal part
	wide_t w_s5 [3];
	side_t side_s5;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			w_s5[i] <= dsh_s4[i] - wide_t'(pn_s4[i]);
		end
		side_s5 <= {2'b00, ok_s4, n_s4[2], n_s4[1], n_s4[0]};
	end

	assign out_valid = vld_s[4];
	assign wvec = w_s5;
	assign side_out = side_s5;

endmodule

[rtl/tnf_cross.sv]
// tnf_cross: cross product of tangent and normal, two register stages
// depends on tnf_pkg
module tnf_cross
	import tnf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  comp_t tan [3],
	input  logic  tan_ok,
	input  side_t side_in,
	output logic  out_valid,
	output wide_t bvec [3],
	output side_t side_out
);

	logic [1:0] vld_s;
	comp_t n_c [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[0], in_valid};
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			n_c[i] = comp_t'(side_in[i*CB +: CB]);
		end
	end

	// stage 1: the six products
	logic signed [2*CB-1:0] pa_s1 [3];
	logic signed [2*CB-1:0] pb_s1 [3];
	comp_t t_s1 [3];
	logic ok_s1;

	always_ff @(posedge clk) begin
		pa_s1[0] <= tan[1] * n_c[2];
		pb_s1[0] <= tan[2] * n_c[1];
		pa_s1[1] <= tan[2] * n_c[0];
		pb_s1[1] <= tan[0] * n_c[2];
		pa_s1[2] <= tan[0] * n_c[1];
		pb_s1[2] <= tan[1] * n_c[0];
		t_s1 <= tan;
		ok_s1 <= tan_ok & side_in[3*CB];
	end

	// stage 2: differences
	wide_t b_s2 [3];
	side_t side_s2;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			b_s2[i] <= wide_t'(pa_s1[i]) - wide_t'(pb_s1[i]);
		end
		side_s2 <= {2'b00, ok_s1, t_s1[2], t_s1[1], t_s1[0]};
	end

	assign out_valid = vld_s[1];
	assign bvec = b_s2;
	assign side_out = side_s2;

endmodule

[rtl/triangle_tangent_frame.sv]
// Tangent frame: one triangle accepted every cycle, busy never rises. Most of the
// pipeline depth lies in the three normalisers, each with a 31-stage square root
// and a 15-stage divider per component.
// Reset clears only the valid bits; done stays low until the first result.
// The receiver cannot stall: each result is shown for exactly one cycle.
// depends on tnf_pkg, tnf_front, tnf_norm, tnf_proj, tnf_cross
module triangle_tangent_frame
	import tnf_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  logic [VW-1:0]  pos_a,
	input  logic [VW-1:0]  pos_b,
	input  logic [VW-1:0]  pos_c,
	input  logic [VW-1:0]  nrm_a,
	input  logic [VW-1:0]  nrm_b,
	input  logic [VW-1:0]  nrm_c,
	input  logic [UVW-1:0] uv_a,
	input  logic [UVW-1:0] uv_b,
	output logic           done,
	output logic [VW-1:0]  tangent_out,
	output logic [VW-1:0]  binormal_out,
	output logic           degenerate
);

	// front end: normal sum and edge
	logic fr_valid;
	wide_t fr_sum [3];
	side_t fr_edge;

	tnf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.pos_a     (pos_a),
		.pos_b     (pos_b),
		.pos_c     (pos_c),
		.nrm_a     (nrm_a),
		.nrm_b     (nrm_b),
		.nrm_c     (nrm_c),
		.uv_a      (uv_a),
		.uv_b      (uv_b),
		.out_valid (fr_valid),
		.nsum      (fr_sum),
		.edge_out  (fr_edge)
	);

	// face normal
	logic n_valid;
	comp_t n_vec [3];
	logic n_ok;
	side_t n_side;

	tnf_norm u_norm_n (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.vin       (fr_sum),
		.side_in   (fr_edge),
		.out_valid (n_valid),
		.vout      (n_vec),
		.nz        (n_ok),
		.side_out  (n_side)
	);

	// projection off the normal
	logic w_valid;
	wide_t w_vec [3];
	side_t w_side;

	tnf_proj u_proj (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (n_valid),
		.nrm       (n_vec),
		.nrm_ok    (n_ok),
		.edge_in   (n_side),
		.out_valid (w_valid),
		.wvec      (w_vec),
		.side_out  (w_side)
	);

	// tangent
	logic t_valid;
	comp_t t_vec [3];
	logic t_ok;
	side_t t_side;

	tnf_norm u_norm_t (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (w_valid),
		.vin       (w_vec),
		.side_in   (w_side),
		.out_valid (t_valid),
		.vout      (t_vec),
		.nz        (t_ok),
		.side_out  (t_side)
	);

	// cross with the normal
	logic c_valid;
	wide_t c_vec [3];
	side_t c_side;

	tnf_cross u_cross (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (t_valid),
		.tan       (t_vec),
		.tan_ok    (t_ok),
		.side_in   (t_side),
		.out_valid (c_valid),
		.bvec      (c_vec),
		.side_out  (c_side)
	);

	// binormal
	logic b_valid;
	comp_t b_vec [3];
	logic b_ok;
	side_t b_side;

	tnf_norm u_norm_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (c_valid),
		.vin       (c_vec),
		.side_in   (c_side),
		.out_valid (b_valid),
		.vout      (b_vec),
		.nz        (b_ok),
		.side_out  (b_side)
	);

	// result register; zero outputs on any zero-length vector
	logic all_ok;
	logic done_q;
	logic deg_q;
	logic [VW-1:0] tan_q;
	logic [VW-1:0] bin_q;

	assign all_ok = b_side[3*CB] & b_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= b_valid;
		end
	end

	always_ff @(posedge clk) begin
		deg_q <= !all_ok;
		tan_q <= all_ok ? b_side[VW-1:0] : '0;
		bin_q <= all_ok ? {b_vec[2], b_vec[1], b_vec[0]} : '0;
	end

	assign busy = 1'b0;
	assign done = done_q;
	assign degenerate = deg_q;
	assign tangent_out = tan_q;
	assign binormal_out = bin_q;

endmodule

[tb/triangle_tangent_frame_test.sv]
// triangle_tangent_frame_test: self-checking bench for the tangent frame pipeline
// depends on tnf_pkg and triangle_tangent_frame; carries its own integer predictor
module triangle_tangent_frame_test;
	import tnf_pkg::*;

	typedef struct {
		logic [VW-1:0] tan;
		logic [VW-1:0] bin;
		logic          degen;
	} frame_t;

	localparam int LATENCY = 168;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           start = 1'b0;
	logic           busy;
	logic [VW-1:0]  pos_a = '0, pos_b = '0, pos_c = '0;
	logic [VW-1:0]  nrm_a = '0, nrm_b = '0, nrm_c = '0;
	logic [UVW-1:0] uv_a = '0, uv_b = '0;
	logic           done;
	logic [VW-1:0]  tangent_out, binormal_out;
	logic           degenerate;

	frame_t frames_due[$];
	int     errors = 0;
	int     gap_pct = 0;

	triangle_tangent_frame dut (.*);

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// limit on the whole run
	initial begin
		#4000000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic longint comp_of(logic [VW-1:0] v, int k);
		comp_t c;
		c = v[k*CB +: CB];
		return longint'(c);
	endfunction

	function automatic longint unsigned root_of(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// scale to [2^29, 2^30), divide by the root of the sum of squares
	function automatic bit unit_vec(input longint v[3], output longint o[3]);
		longint unsigned mag[3], mx, l2, m, q, lim;
		mx = 0;
		l2 = 0;
		lim = (64'd1 << (CB - 1)) - 1;
		for (int i = 0; i < 3; i++) begin
			mag[i] = v[i] < 0 ? -v[i] : v[i];
			if (mag[i] > mx) mx = mag[i];
		end
		if (mx == 0) return 1'b0;
		while (mx >= (64'd1 << 30)) begin
			for (int i = 0; i < 3; i++) mag[i] >>= 1;
			mx >>= 1;
		end
		while (mx < (64'd1 << 29)) begin
			for (int i = 0; i < 3; i++) mag[i] <<= 1;
			mx <<= 1;
		end
		for (int i = 0; i < 3; i++) l2 += mag[i] * mag[i];
		m = root_of(l2);
		for (int i = 0; i < 3; i++) begin
			q = ((mag[i] << NF) + m / 2) / m;
			if (q > lim) q = lim;
			o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
		end
		return 1'b1;
	endfunction

	function automatic logic [VW-1:0] pack_vec(longint v[3]);
		logic [VW-1:0] r;
		for (int k = 0; k < 3; k++) r[k*CB +: CB] = v[k][CB-1:0];
		return r;
	endfunction

	function automatic frame_t tangent_frame(logic [VW-1:0] pa, pb, pc, na, nb, nc,
			logic [UVW-1:0] ua, ub);
		longint s[3], n[3], d[3], w[3], t[3], b[3], bo[3];
		longint du, p, pr;
		longint unsigned pm;
		bit same, ok;
		frame_t f;
		same = 1'b1;
		for (int i = 0; i < 3; i++) begin
			s[i] = comp_of(na, i) + comp_of(nb, i) + comp_of(nc, i);
			if (comp_of(pa, i) != comp_of(pb, i)) same = 1'b0;
		end
		for (int i = 0; i < 3; i++)
			d[i] = comp_of(same ? pc : pb, i) - comp_of(pa, i);
		du = longint'(comp_t'(ub[CB-1:0])) - longint'(comp_t'(ua[CB-1:0]));
		if (du < 0)
			for (int i = 0; i < 3; i++) d[i] = -d[i];
		ok = unit_vec(s, n);
		if (ok) begin
			p = n[0] * d[0] + n[1] * d[1] + n[2] * d[2];
			pm = p < 0 ? -p : p;
			pm = (pm + (64'd1 << (NF - 1))) >> NF;
			pr = p < 0 ? -longint'(pm) : longint'(pm);
			for (int i = 0; i < 3; i++) w[i] = d[i] * (64'sd1 << NF) - pr * n[i];
			ok = unit_vec(w, t);
		end
		if (ok) begin
			b[0] = t[1] * n[2] - t[2] * n[1];
			b[1] = t[2] * n[0] - t[0] * n[2];
			b[2] = t[0] * n[1] - t[1] * n[0];
			ok = unit_vec(b, bo);
		end
		if (ok) begin
			f.tan = pack_vec(t);
			f.bin = pack_vec(bo);
			f.degen = 1'b0;
		end else begin
			f.tan = '0;
			f.bin = '0;
			f.degen = 1'b1;
		end
		return f;
	endfunction

	// result checker
	always @(posedge clk) begin
		frame_t e;
		if (arst_n && done) begin
			if (frames_due.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				e = frames_due.pop_front();
				if (tangent_out !== e.tan) begin
					$error("tangent_out expected %h actual %h", e.tan, tangent_out);
					errors++;
				end
				if (binormal_out !== e.bin) begin
					$error("binormal_out expected %h actual %h", e.bin, binormal_out);
					errors++;
				end
				if (degenerate !== e.degen) begin
					$error("degenerate expected %b actual %b", e.degen, degenerate);
					errors++;
				end
			end
		end
	end

	// one triangle transfer, with random idle cycles before it
	task automatic send_tri(logic [VW-1:0] pa, pb, pc, na, nb, nc,
			logic [UVW-1:0] ua, ub);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		pos_a <= pa; pos_b <= pb; pos_c <= pc;
		nrm_a <= na; nrm_b <= nb; nrm_c <= nc;
		uv_a <= ua; uv_b <= ub;
		@(posedge clk);
		while (busy) @(posedge clk);
		frames_due = {frames_due, tangent_frame(pa, pb, pc, na, nb, nc, ua, ub)};
	endtask

	function automatic logic [VW-1:0] rand_vec();
		return VW'({$urandom, $urandom});
	endfunction

	// small component, to keep normals and edges plausible
	function automatic logic [VW-1:0] near_vec(int span);
		logic [VW-1:0] r;
		for (int k = 0; k < 3; k++)
			r[k*CB +: CB] = CB'($urandom_range(2 * span) - span);
		return r;
	endfunction

	task automatic drain();
		start <= 1'b0;
		while (frames_due.size() != 0) @(posedge clk);
	endtask

	localparam logic [CB-1:0] ONE_N = CB'(1 << NF);
	localparam logic [CB-1:0] MAXC = {1'b0, {(CB-1){1'b1}}};
	localparam logic [CB-1:0] MINC = {1'b1, {(CB-1){1'b0}}};

	task automatic test_directed();
		logic [VW-1:0] nz, px, py;
		nz = {ONE_N, {CB{1'b0}}, {CB{1'b0}}};
		px = {{2*CB{1'b0}}, CB'(256)};
		py = {{CB{1'b0}}, CB'(256), {CB{1'b0}}};
		// plain frame, du positive
		send_tri('0, px, py, nz, nz, nz, 32'h0, 32'h1000);
		// du negative flips the edge
		send_tri('0, px, py, nz, nz, nz, 32'h1000, 32'h0);
		// du zero
		send_tri('0, px, py, nz, nz, nz, 32'h5, 32'h5);
		// corners 0 and 1 coincide: use corner 2
		send_tri(px, px, py, nz, nz, nz, 32'h0, 32'h1000);
		// normals cancel: degenerate
		send_tri('0, px, py, nz, '0, {(-ONE_N), {2*CB{1'b0}}}, 0, 1);
		// edge parallel to the normal: degenerate
		send_tri('0, {CB'(256), {2*CB{1'b0}}}, py, nz, nz, nz, 0, 1);
		// all corners equal: zero edge
		send_tri(px, px, px, nz, nz, nz, 0, 1);
		// extreme components
		send_tri({3{MINC}}, {3{MAXC}}, {3{MINC}}, {3{MAXC}}, {3{MAXC}}, {3{MAXC}},
			{2{MINC}}, {2{MAXC}});
		send_tri({3{MAXC}}, {3{MINC}}, '0, {3{MINC}}, {3{MINC}}, {3{MINC}},
			{2{MAXC}}, {2{MINC}});
		send_tri('1, '0, '1, '1, '1, '1, '1, '0);
		send_tri('0, '1, '0, '0, '0, {3{16'h0001}}, '0, '1);
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(3) == 0)
				send_tri(rand_vec(), rand_vec(), rand_vec(), rand_vec(), rand_vec(),
					rand_vec(), $urandom, $urandom);
			else
				send_tri(near_vec(4000), near_vec(4000), near_vec(4000),
					near_vec(16384), near_vec(16384), near_vec(16384),
					$urandom, $urandom);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		// sender pauses until every result is back
		drain();
		gap_pct = 34;
		test_random(220);
		gap_pct = 72;
		test_random(210);
		gap_pct = 0;
		test_random(210);
		drain();
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
